FILE: hdl/itg_pkg.sv
// Shared types, constants and lookup functions for the image tile geometry block.
package itg_pkg;

	localparam int MAX_GRID = 7;
	localparam int MAX_DIM  = 16383;

	localparam int FACTOR_W = 5;
	localparam int DIM_W    = 14;
	localparam int FRAG_W   = 15;
	localparam int GRID_W   = 3;
	localparam int IDX_W    = 3;
	localparam int KERN_W   = 8;
	localparam int BORDER_W = 9;
	localparam int PC_W     = 4;
	localparam int REG_W    = 14;
	localparam int RADDR_W  = 3;

	// reciprocal divide: q = (n * RECIP[d]) >> RECIP_SH, exact for n < 2**DIM_W, d <= 7
	localparam int RECIP_SH = 17;
	localparam int RECIP_W  = 18;
	localparam int PROD_W   = DIM_W + RECIP_W;

	typedef enum logic [RADDR_W-1:0] {
		REG_TILE_FACTOR   = 3'd0,
		REG_IMAGE_WIDTH   = 3'd1,
		REG_IMAGE_HEIGHT  = 3'd2,
		REG_BASE_BORDER   = 3'd3,
		REG_FILTER_ENABLE = 3'd4,
		REG_KERNEL_WIDTH  = 3'd5,
		REG_KERNEL_HEIGHT = 3'd6
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_BAD_FACTOR = 2'd1,
		ST_OUT_OF_GRID = 2'd2
	} status_t;

	localparam logic [PC_W-1:0] PC_SINGLE    = 4'd0;
	localparam logic [PC_W-1:0] PC_GRID_BASE = 4'd1;
	localparam logic [PC_W-1:0] PC_ROW_BASE  = 4'd10;
	localparam logic [PC_W-1:0] PC_COL_BASE  = 4'd13;
	localparam logic [PC_W-1:0] PC_ROW_STEP  = 4'd3;

	localparam logic [1:0] AX_FIRST  = 2'd0;
	localparam logic [1:0] AX_MIDDLE = 2'd1;
	localparam logic [1:0] AX_LAST   = 2'd2;

	typedef struct packed {
		logic [IDX_W-1:0] tile_row;
		logic [IDX_W-1:0] tile_col;
	} tile_req_t;

	typedef struct packed {
		logic [GRID_W-1:0] grid_cols;
		logic [GRID_W-1:0] grid_rows;
		logic [DIM_W-1:0]  core_width;
		logic [DIM_W-1:0]  core_height;
		logic [FRAG_W-1:0] frag_width;
		logic [FRAG_W-1:0] frag_height;
		logic [PC_W-1:0]   position_class;
		status_t           status;
	} tile_res_t;

	typedef struct packed {
		logic en_s2;
		logic en_s3;
		logic en_s4;
	} stage_en_t;

	typedef struct packed {
		logic              ok;
		logic [GRID_W-1:0] lng;
		logic [GRID_W-1:0] sht;
	} grid_t;

	function automatic grid_t pick_grid(input logic [FACTOR_W-1:0] f);
		grid_t g;
		g.ok  = 1'b1;
		g.lng = 3'd1;
		g.sht = 3'd1;
		case (f) inside
			5'd1:            begin g.lng = 3'd1; g.sht = 3'd1; end
			5'd2:            begin g.lng = 3'd2; g.sht = 3'd1; end
			5'd4:            begin g.lng = 3'd2; g.sht = 3'd2; end
			5'd6:            begin g.lng = 3'd3; g.sht = 3'd2; end
			5'd8:            begin g.lng = 3'd4; g.sht = 3'd2; end
			5'd10:           begin g.lng = 3'd5; g.sht = 3'd2; end
			5'd12, 5'd14:    begin g.lng = 3'd4; g.sht = 3'd3; end
			5'd16:           begin g.lng = 3'd4; g.sht = 3'd4; end
			5'd18:           begin g.lng = 3'd6; g.sht = 3'd3; end
			5'd20, 5'd22:    begin g.lng = 3'd5; g.sht = 3'd4; end
			5'd24, 5'd26:    begin g.lng = 3'd6; g.sht = 3'd4; end
			[5'd28:5'd31]:   begin g.lng = GRID_W'(MAX_GRID); g.sht = 3'd4; end
			default:         g.ok = 1'b0;
		endcase
		return g;
	endfunction

	function automatic logic [RECIP_W-1:0] recip(input logic [GRID_W-1:0] d);
		logic [RECIP_W-1:0] r;
		case (d)
			3'd1:    r = 18'd131072;
			3'd2:    r = 18'd65536;
			3'd3:    r = 18'd43691;
			3'd4:    r = 18'd32768;
			3'd5:    r = 18'd26215;
			3'd6:    r = 18'd21846;
			3'd7:    r = 18'd18725;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic [1:0] axis_pos(input logic [IDX_W-1:0] i,
			input logic [GRID_W-1:0] n);
		logic [1:0] p;
		if (i == '0)
			p = AX_FIRST;
		else if (i == n - GRID_W'(1))
			p = AX_LAST;
		else
			p = AX_MIDDLE;
		return p;
	endfunction

	function automatic logic [PC_W-1:0] pos_class(input logic [IDX_W-1:0] row,
			input logic [IDX_W-1:0] col, input logic [GRID_W-1:0] rows,
			input logic [GRID_W-1:0] cols);
		logic [1:0] ar;
		logic [1:0] ac;
		logic [PC_W-1:0] pc;
		ar = axis_pos(row, rows);
		ac = axis_pos(col, cols);
		if (rows == 3'd1 && cols == 3'd1)
			pc = PC_SINGLE;
		else if (rows == 3'd1)
			pc = PC_ROW_BASE + PC_W'(ac);
		else if (cols == 3'd1)
			pc = PC_COL_BASE + PC_W'(ar);
		else
			pc = PC_GRID_BASE + PC_ROW_STEP * PC_W'(ar) + PC_W'(ac);
		return pc;
	endfunction

endpackage

FILE: hdl/itg_axis.sv
// One axis of the tile geometry: divide by grid count, remainder to last tile, add halo.
module itg_axis (
	input  logic                         clk,
	input  itg_pkg::stage_en_t           en,
	input  logic [itg_pkg::DIM_W-1:0]    dim,
	input  logic [itg_pkg::GRID_W-1:0]   cnt,
	input  logic                         last,
	input  logic [itg_pkg::BORDER_W-1:0] border,
	output logic [itg_pkg::DIM_W-1:0]    core,
	output logic [itg_pkg::FRAG_W-1:0]   frag
);
	import itg_pkg::*;

	logic [PROD_W-1:0]        prod_s2;
	logic [DIM_W-1:0]         dim_s2;
	logic [GRID_W-1:0]        cnt_s2;
	logic                     last_s2;
	logic [BORDER_W-1:0]      border_s2;

	logic [DIM_W-1:0]         quo;
	logic [DIM_W+GRID_W-1:0]  qd;
	logic [DIM_W-1:0]         q_s3;
	logic [DIM_W-1:0]         rem_s3;
	logic                     last_s3;
	logic [BORDER_W-1:0]      border_s3;

	logic [DIM_W-1:0]         core_d;
	logic [DIM_W-1:0]         core_s4;
	logic [FRAG_W-1:0]        frag_s4;

	always_ff @(posedge clk) begin
		if (en.en_s2) begin
			prod_s2   <= PROD_W'(dim) * PROD_W'(recip(cnt));
			dim_s2    <= dim;
			cnt_s2    <= cnt;
			last_s2   <= last;
			border_s2 <= border;
		end
	end

	assign quo = prod_s2[RECIP_SH +: DIM_W];
	assign qd  = (DIM_W+GRID_W)'(quo) * (DIM_W+GRID_W)'(cnt_s2);

	always_ff @(posedge clk) begin
		if (en.en_s3) begin
			q_s3      <= quo;
			rem_s3    <= dim_s2 - qd[DIM_W-1:0];
			last_s3   <= last_s2;
			border_s3 <= border_s2;
		end
	end

	assign core_d = last_s3 ? q_s3 + rem_s3 : q_s3;

	always_ff @(posedge clk) begin
		if (en.en_s4) begin
			core_s4 <= core_d;
			frag_s4 <= FRAG_W'(core_d) + FRAG_W'({border_s3, 1'b0});
		end
	end

	assign core = core_s4;
	assign frag = frag_s4;

endmodule

FILE: hdl/image_tile_geometry.sv
// Top level of the image tile geometry block: registers, grid selection and pipeline control.
// A tile query (row, column) gives the chosen grid, the tile's core and fragment size,
// its position class and a status. The block is a four-stage pipeline: it takes one query
// every cycle while req_ready is high and returns results in order. Stage 1 holds the query,
// stage 2 the image side times the reciprocal of the grid count, stage 3 quotient and
// remainder, stage 4 the last-tile correction and halo add. The user must write registers
// through wr_en/wr_index/wr_data only while no query is in flight; the block does not enforce it.
module image_tile_geometry (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  itg_pkg::tile_req_t          req,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output itg_pkg::tile_res_t          rsp,
	input  logic                        wr_en,
	input  logic [itg_pkg::RADDR_W-1:0] wr_index,
	input  logic [itg_pkg::REG_W-1:0]   wr_data
);
	import itg_pkg::*;

	// configuration
	logic [FACTOR_W-1:0] tile_factor_q;
	logic [DIM_W-1:0]    image_width_q;
	logic [DIM_W-1:0]    image_height_q;
	logic [KERN_W-1:0]   base_border_q;
	logic                filter_enable_q;
	logic [KERN_W-1:0]   kernel_width_q;
	logic [KERN_W-1:0]   kernel_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_factor_q   <= FACTOR_W'(1);
			image_width_q   <= DIM_W'(1);
			image_height_q  <= DIM_W'(1);
			base_border_q   <= '0;
			filter_enable_q <= 1'b0;
			kernel_width_q  <= '0;
			kernel_height_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_TILE_FACTOR:   tile_factor_q   <= wr_data[FACTOR_W-1:0];
				REG_IMAGE_WIDTH:   image_width_q   <= wr_data[DIM_W-1:0];
				REG_IMAGE_HEIGHT:  image_height_q  <= wr_data[DIM_W-1:0];
				REG_BASE_BORDER:   base_border_q   <= wr_data[KERN_W-1:0];
				REG_FILTER_ENABLE: filter_enable_q <= wr_data[0];
				REG_KERNEL_WIDTH:  kernel_width_q  <= wr_data[KERN_W-1:0];
				REG_KERNEL_HEIGHT: kernel_height_q <= wr_data[KERN_W-1:0];
				default: ;
			endcase
		end
	end

	// pipeline control
	logic      v_s1, v_s2, v_s3, v_s4;
	logic      en1;
	stage_en_t en;

	assign en.en_s4 = !v_s4 || rsp_ready;
	assign en.en_s3 = !v_s3 || en.en_s4;
	assign en.en_s2 = !v_s2 || en.en_s3;
	assign en1      = !v_s1 || en.en_s2;
	assign req_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1)
				v_s1 <= req_valid;
			if (en.en_s2)
				v_s2 <= v_s1;
			if (en.en_s3)
				v_s3 <= v_s2;
			if (en.en_s4)
				v_s4 <= v_s3;
		end
	end

	// stage 1: tile index
	tile_req_t req_s1;

	always_ff @(posedge clk) begin
		if (en1)
			req_s1 <= req;
	end

	grid_t               grid;
	logic [DIM_W-1:0]    w_cl, h_cl;
	logic [GRID_W-1:0]   cols, rows;
	logic [BORDER_W-1:0] bx, by;
	logic                last_col, last_row;
	status_t             status_d;
	logic [PC_W-1:0]     pc_d;

	always_comb begin
		grid = pick_grid(tile_factor_q);
		w_cl = (32'(image_width_q) > MAX_DIM) ? DIM_W'(MAX_DIM) : image_width_q;
		h_cl = (32'(image_height_q) > MAX_DIM) ? DIM_W'(MAX_DIM) : image_height_q;
		if (w_cl > h_cl) begin
			cols = grid.lng;
			rows = grid.sht;
		end else begin
			cols = grid.sht;
			rows = grid.lng;
		end
		bx = BORDER_W'(base_border_q)
			+ (filter_enable_q ? BORDER_W'(kernel_width_q[KERN_W-1:1]) : '0);
		by = BORDER_W'(base_border_q)
			+ (filter_enable_q ? BORDER_W'(kernel_height_q[KERN_W-1:1]) : '0);
		last_col = req_s1.tile_col == cols - GRID_W'(1);
		last_row = req_s1.tile_row == rows - GRID_W'(1);
		if (!grid.ok)
			status_d = ST_BAD_FACTOR;
		else if (req_s1.tile_row >= rows || req_s1.tile_col >= cols)
			status_d = ST_OUT_OF_GRID;
		else
			status_d = ST_OK;
		pc_d = pos_class(req_s1.tile_row, req_s1.tile_col, rows, cols);
	end

	// stages 2..4: grid, class and status travel alongside the dividers
	logic [GRID_W-1:0] cols_s2, rows_s2, cols_s3, rows_s3, cols_s4, rows_s4;
	logic [PC_W-1:0]   pc_s2, pc_s3, pc_s4;
	status_t           status_s2, status_s3, status_s4;

	always_ff @(posedge clk) begin
		if (en.en_s2) begin
			cols_s2   <= cols;
			rows_s2   <= rows;
			pc_s2     <= pc_d;
			status_s2 <= status_d;
		end
		if (en.en_s3) begin
			cols_s3   <= cols_s2;
			rows_s3   <= rows_s2;
			pc_s3     <= pc_s2;
			status_s3 <= status_s2;
		end
		if (en.en_s4) begin
			cols_s4   <= cols_s3;
			rows_s4   <= rows_s3;
			pc_s4     <= pc_s3;
			status_s4 <= status_s3;
		end
	end

	logic [DIM_W-1:0]  core_w, core_h;
	logic [FRAG_W-1:0] frag_w, frag_h;

	itg_axis u_axis_x (
		.clk    (clk),
		.en     (en),
		.dim    (w_cl),
		.cnt    (cols),
		.last   (last_col),
		.border (bx),
		.core   (core_w),
		.frag   (frag_w)
	);

	itg_axis u_axis_y (
		.clk    (clk),
		.en     (en),
		.dim    (h_cl),
		.cnt    (rows),
		.last   (last_row),
		.border (by),
		.core   (core_h),
		.frag   (frag_h)
	);

	logic ok_s4, grid_ok_s4;

	assign ok_s4      = status_s4 == ST_OK;
	assign grid_ok_s4 = status_s4 != ST_BAD_FACTOR;
	assign rsp_valid  = v_s4;

	always_comb begin
		rsp.grid_cols      = grid_ok_s4 ? cols_s4 : '0;
		rsp.grid_rows      = grid_ok_s4 ? rows_s4 : '0;
		rsp.core_width     = ok_s4 ? core_w : '0;
		rsp.core_height    = ok_s4 ? core_h : '0;
		rsp.frag_width     = ok_s4 ? frag_w : '0;
		rsp.frag_height    = ok_s4 ? frag_h : '0;
		rsp.position_class = ok_s4 ? pc_s4 : '0;
		rsp.status         = status_s4;
	end

	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> v_s1)
		else $error("accepted query did not enter stage 1");

	a_stall_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !en.en_s3 |=> v_s2)
		else $error("stalled stage 2 lost its item");

	a_bad_factor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_BAD_FACTOR |->
		rsp.grid_cols == '0 && rsp.grid_rows == '0 && rsp.core_width == '0)
		else $error("unsupported factor result not cleared");

	a_ok_grid: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_OK |->
		rsp.grid_cols != '0 && rsp.grid_rows != '0
		&& rsp.frag_width >= FRAG_W'(rsp.core_width))
		else $error("valid tile with empty grid or short fragment");

endmodule
